/* sv/atcb_pkg.sv */
`default_nettype none
package atcb_pkg;

  typedef logic [15:0] count_t;
  typedef logic [2:0]  mode_t;
  typedef logic [1:0]  func_t;

  localparam func_t FUNC_REBOOT = 2'd0;
  localparam func_t FUNC_TASK   = 2'd1;
  localparam func_t FUNC_COMMIT = 2'd2;
  localparam func_t FUNC_NOP    = 2'd3;

  localparam mode_t MODE_SLOW       = 3'd0;
  localparam mode_t MODE_FAST       = 3'd1;
  localparam mode_t MODE_FAST_TASK  = 3'd2;
  localparam mode_t MODE_VALLEY     = 3'd3;
  localparam mode_t MODE_VALLEY_TASK = 3'd4;
  localparam mode_t MODE_WICKED     = 3'd5;

  localparam count_t MAX_TARGET   = 16'h0040;
  localparam count_t TARGET_RESET = 16'd1;
  localparam count_t TOTAL_RESET  = 16'd10;

  localparam int OUT_BITS = 49;
  localparam int OUT_TDATA_BITS = 56;

endpackage
`default_nettype wire

/* sv/adaptive_task_coalescing_budget_core.sv */
// A result is registered and appears on the output in the cycle after its item is accepted.
// Throughput: one item per cycle; the input stays ready while the output register is
// empty or being drained in the same cycle.
// Reset (rst, synchronous): target 1, total 10, budget 0, history and last total 0,
// decreasing set, mode slow, output register empty.
`default_nettype none
module adaptive_task_coalescing_budget_core (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   cfg_we,
  input  wire atcb_pkg::mode_t  cfg_wdata,      // alg_mode
  input  wire                   s_axis_tvalid,
  output logic                  s_axis_tready,
  input  wire [7:0]             s_axis_tdata,   // [7:0] task_weight
  input  wire atcb_pkg::func_t  s_axis_tuser,   // [1:0] func
  output logic                  m_axis_tvalid,
  input  wire                   m_axis_tready,
  output logic [55:0]           m_axis_tdata    // [15:0] target_budget, [31:16] budget_count,
                                                // [47:32] total_count, [48] budget_reached
);
  import atcb_pkg::*;

  mode_t  alg_mode;
  count_t target_reg, total_reg, budget_reg, last_total_reg;
  count_t hist0, hist1;
  logic   decreasing;

  count_t target_next, total_next, budget_next, last_total_next;
  count_t hist0_next, hist1_next;
  logic   decreasing_next;

  logic   acc;
  mode_t  mode;
  logic   weighted, valley;
  count_t inc;
  logic [17:0] hist_sum;
  count_t mean, t_half1, t_wick, halved, doubled;
  count_t tgt_commit;
  logic   [OUT_BITS-1:0] result;

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign acc = s_axis_tvalid && s_axis_tready;

  always_comb begin
    mode = (alg_mode > MODE_WICKED) ? MODE_SLOW : alg_mode;
    weighted = (mode == MODE_FAST_TASK) || (mode == MODE_VALLEY_TASK) || (mode == MODE_WICKED);
    valley = (mode == MODE_VALLEY) || (mode == MODE_VALLEY_TASK);
    inc = weighted ? {8'd0, s_axis_tdata} : 16'd1;
    hist_sum = {2'b00, total_reg} + {2'b00, hist0} + {2'b00, hist1};
    mean = hist_sum[17:2];
    t_half1 = {1'b0, total_reg[15:1]} + 16'd1;
    // 3*(t>>2) + (t&3)
    t_wick = {1'b0, total_reg[15:2], 1'b0} + {2'b00, total_reg[15:2]} + {14'd0, total_reg[1:0]};
    halved = {1'b0, target_reg[15:1]};
    doubled = {target_reg[14:0], 1'b0};

    target_next = target_reg;
    total_next = total_reg;
    budget_next = budget_reg;
    last_total_next = last_total_reg;
    hist0_next = hist0;
    hist1_next = hist1;
    decreasing_next = decreasing;
    tgt_commit = target_reg;

    case (s_axis_tuser)
      FUNC_REBOOT: begin
        budget_next = '0;
        decreasing_next = 1'b1;
        last_total_next = valley ? total_reg : '0;
        if (mode == MODE_SLOW) begin
          if (target_reg > 16'd1) target_next = target_reg - 16'd1;
        end else if (mode == MODE_WICKED) begin
          target_next = (total_reg >= mean) ? t_wick : t_half1;
          hist1_next = hist0;
          hist0_next = total_reg;
        end else begin
          target_next = t_half1;
        end
        total_next = '0;
      end
      FUNC_TASK: begin
        budget_next = budget_reg + inc;
        total_next = total_reg + inc;
      end
      FUNC_COMMIT: begin
        if (mode == MODE_SLOW) begin
          tgt_commit = target_reg + 16'd1;
        end else if (mode == MODE_FAST || mode == MODE_FAST_TASK) begin
          tgt_commit = t_half1;
        end else if (decreasing) begin
          if (target_reg > 16'd1) begin
            tgt_commit = halved;
          end else begin
            decreasing_next = 1'b0;
            tgt_commit = doubled;
          end
        end else if (target_reg < last_total_reg) begin
          tgt_commit = doubled;
        end else begin
          decreasing_next = 1'b1;
          tgt_commit = halved;
        end
        target_next = (tgt_commit > MAX_TARGET) ? MAX_TARGET : tgt_commit;
        budget_next = '0;
      end
      default: begin
      end
    endcase

    result = {(budget_next >= target_next), total_next, budget_next, target_next};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      alg_mode <= MODE_SLOW;
      target_reg <= TARGET_RESET;
      total_reg <= TOTAL_RESET;
      budget_reg <= '0;
      last_total_reg <= '0;
      hist0 <= '0;
      hist1 <= '0;
      decreasing <= 1'b1;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_we) alg_mode <= cfg_wdata;
      if (acc) begin
        target_reg <= target_next;
        total_reg <= total_next;
        budget_reg <= budget_next;
        last_total_reg <= last_total_next;
        hist0 <= hist0_next;
        hist1 <= hist1_next;
        decreasing <= decreasing_next;
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // payload register, no reset
  always_ff @(posedge clk) begin
    if (acc) m_axis_tdata <= {{(OUT_TDATA_BITS-OUT_BITS){1'b0}}, result};
  end

  a_commit_cap: assert property (@(posedge clk) disable iff (rst)
    (acc && s_axis_tuser == FUNC_COMMIT) |=> (target_reg <= MAX_TARGET && budget_reg == '0))
    else $error("target above cap or budget not cleared after commit");

  a_reboot_clear: assert property (@(posedge clk) disable iff (rst)
    (acc && s_axis_tuser == FUNC_REBOOT) |=> (total_reg == '0 && budget_reg == '0 && decreasing))
    else $error("reboot did not clear counts");

  a_out_matches_state: assert property (@(posedge clk) disable iff (rst)
    acc |=> (m_axis_tdata[15:0] == target_reg && m_axis_tdata[31:16] == budget_reg &&
             m_axis_tdata[47:32] == total_reg))
    else $error("result does not match updated state");

  a_reached_flag: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[48] == (m_axis_tdata[31:16] >= m_axis_tdata[15:0])))
    else $error("budget_reached inconsistent");

  a_valid_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(acc))
    else $error("result shown without an accepted item");

endmodule
`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 1ps
module testbench;
  import atcb_pkg::*;

  // Field order matches m_axis_tdata from bit 48 down to bit 0.
  typedef struct packed {
    logic   reached;
    count_t total;
    count_t budget;
    count_t target;
  } status_t;

  typedef struct packed {
    mode_t       mode;
    func_t       f;
    logic [7:0]  w;
    logic        typed;
    status_t     want;
  } plan_row_t;

  localparam int    RANDOM_ITEMS   = 1250;
  localparam int    STALL_LIMIT    = 3000;
  localparam int    LONG_HOLD      = 300;
  localparam int    WRAP_TASKS     = 280;
  localparam mode_t MODE_UNDEF_TOP = 3'd7;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  mode_t      cfg_wdata = MODE_SLOW;
  logic       s_axis_tvalid = 1'b0;
  wire        s_axis_tready;
  logic [7:0] s_axis_tdata = 8'd0;
  func_t      s_axis_tuser = FUNC_NOP;
  wire        m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  wire [55:0] m_axis_tdata;

  // Travels with each item: a hand-written expectation replaces the prediction.
  logic    item_typed = 1'b0;
  status_t item_want = '0;

  // Predicted block state.
  mode_t  cur_mode;
  count_t c_target, c_total, c_budget, last_total;
  count_t hist [2];
  logic   falling;

  status_t status_due_q [$];
  int items_sent = 0;
  int results_out = 0;
  int mismatches = 0;
  int n_reboots = 0, n_commits = 0, n_reached = 0, n_mode_writes = 0;
  int idle_cycles = 0;
  logic quiet = 1'b0;
  logic hold_req = 1'b0;

  adaptive_task_coalescing_budget_core dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #10 clk = ~clk;

  function automatic status_t next_status(input func_t f, input logic [7:0] w);
    mode_t       m;
    logic [17:0] mean;
    count_t      inc;
    status_t     r;
    m = (cur_mode > MODE_WICKED) ? MODE_SLOW : cur_mode;
    case (f)
      FUNC_REBOOT: begin
        c_budget = '0;
        falling = 1'b1;
        last_total = (m == MODE_VALLEY || m == MODE_VALLEY_TASK) ? c_total : '0;
        if (m == MODE_SLOW) begin
          if (c_target > 16'd1) c_target = c_target - 16'd1;
        end else if (m == MODE_WICKED) begin
          // sum over this run and the two before it, divided by four, no wrap
          mean = ({2'b00, c_total} + {2'b00, hist[0]} + {2'b00, hist[1]}) >> 2;
          if ({2'b00, c_total} >= mean) c_target = 16'(3 * (c_total >> 2) + (c_total & 16'd3));
          else c_target = (c_total >> 1) + 16'd1;
          hist[1] = hist[0];
          hist[0] = c_total;
        end else begin
          c_target = (c_total >> 1) + 16'd1;
        end
        c_total = '0;
      end
      FUNC_TASK: begin
        inc = (m == MODE_FAST_TASK || m == MODE_VALLEY_TASK || m == MODE_WICKED) ?
              {8'd0, w} : 16'd1;
        c_budget = c_budget + inc;
        c_total = c_total + inc;
      end
      FUNC_COMMIT: begin
        if (m == MODE_SLOW) begin
          c_target = c_target + 16'd1;
        end else if (m == MODE_FAST || m == MODE_FAST_TASK) begin
          c_target = (c_total >> 1) + 16'd1;
        end else if (falling) begin
          if (c_target > 16'd1) c_target = c_target >> 1;
          else begin
            falling = 1'b0;
            c_target = c_target << 1;
          end
        end else if (c_target < last_total) begin
          c_target = c_target << 1;
        end else begin
          falling = 1'b1;
          c_target = c_target >> 1;
        end
        if (c_target > MAX_TARGET) c_target = MAX_TARGET;
        c_budget = '0;
      end
      default: ;
    endcase
    r.target = c_target;
    r.budget = c_budget;
    r.total = c_total;
    r.reached = (c_budget >= c_target);
    return r;
  endfunction

  task automatic check_field(input string name, input count_t want, input count_t got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // Track config writes, predict each accepted item, compare each result.
  always @(posedge clk) begin
    status_t got, want;
    if (rst) begin
      cur_mode = MODE_SLOW;
      c_target = TARGET_RESET;
      c_total = TOTAL_RESET;
      c_budget = '0;
      hist[0] = '0;
      hist[1] = '0;
      last_total = '0;
      falling = 1'b1;
    end else begin
      if (cfg_we) begin
        cur_mode = cfg_wdata;
        n_mode_writes++;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        want = next_status(s_axis_tuser, s_axis_tdata);
        status_due_q.push_back(item_typed ? item_want : want);
        if (s_axis_tuser == FUNC_REBOOT) n_reboots++;
        if (s_axis_tuser == FUNC_COMMIT) n_commits++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = status_t'(m_axis_tdata[48:0]);
        results_out++;
        if (status_due_q.size() == 0) begin
          mismatches++;
          $display("%0t: result with nothing expected, got %h", $time, got);
        end else begin
          want = status_due_q.pop_front();
          check_field("target_budget", want.target, got.target);
          check_field("budget_count", want.budget, got.budget);
          check_field("total_count", want.total, got.total);
          check_field("budget_reached", {15'd0, want.reached}, {15'd0, got.reached});
          if (got.reached === 1'b1) n_reached++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles = 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, idle_cycles);
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles++;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] rand_weight();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  // Result side: random stalls, plus one long hold on request.
  initial begin
    int stall;
    stall = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        stall = LONG_HOLD;
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        stall--;
      end else begin
        m_axis_tready <= 1'b1;
        if (!quiet && $urandom_range(0, 5) == 0) stall = pick_gap();
      end
    end
  end

  task automatic send_item(input func_t f, input logic [7:0] w,
                           input logic typed, input status_t want);
    int gap;
    gap = (!quiet && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= f;
    s_axis_tdata <= w;
    item_typed <= typed;
    item_want <= want;
    do @(posedge clk); while (!s_axis_tready);
    items_sent++;
  endtask

  task automatic send_random(input func_t f);
    send_item(f, rand_weight(), 1'b0, '0);
  endtask

  // Drop valid and wait until every result is back.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (results_out < items_sent) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic set_mode(input mode_t m);
    cfg_we <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Power cycles: usually a reboot, then rounds of finished tasks closed by a commit.
  task automatic power_cycles(input int n, input logic pause_mid);
    int   stop, tasks_n;
    logic pause_left;
    stop = items_sent + n;
    pause_left = pause_mid;
    while (items_sent < stop) begin
      if ($urandom_range(0, 7) != 0) send_random(FUNC_REBOOT);
      repeat ($urandom_range(1, 5)) begin
        tasks_n = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 6);
        repeat (tasks_n) begin
          if ($urandom_range(0, 19) == 0) send_random(func_t'($urandom_range(0, 3)));
          else send_random(FUNC_TASK);
        end
        send_random(FUNC_COMMIT);
      end
      if (pause_left && items_sent >= stop - n / 2) begin
        settle();
        pause_left = 1'b0;
      end
    end
  endtask

  // Heavy tasks with no commit in between: both counts wrap.
  task automatic wrap_burst();
    send_random(FUNC_REBOOT);
    repeat (WRAP_TASKS) send_item(FUNC_TASK, 8'($urandom_range(240, 255)), 1'b0, '0);
    send_random(FUNC_COMMIT);
    send_random(FUNC_REBOOT);
  endtask

  initial begin
    plan_row_t plan [23];
    mode_t     mode_now;
    int        phase, goal;
    plan = '{
      {MODE_SLOW,        FUNC_NOP,    8'h00, 1'b1, {1'b0, 16'd10,  16'd0, 16'd1}},
      {MODE_SLOW,        FUNC_TASK,   8'hFF, 1'b1, {1'b1, 16'd11,  16'd1, 16'd1}},
      {MODE_SLOW,        FUNC_COMMIT, 8'h00, 1'b1, {1'b0, 16'd11,  16'd0, 16'd2}},
      {MODE_SLOW,        FUNC_REBOOT, 8'hFF, 1'b1, {1'b0, 16'd0,   16'd0, 16'd1}},
      {MODE_FAST,        FUNC_TASK,   8'h00, 1'b0, 49'd0},
      {MODE_FAST,        FUNC_COMMIT, 8'h00, 1'b0, 49'd0},
      {MODE_FAST_TASK,   FUNC_TASK,   8'hFF, 1'b0, 49'd0},
      {MODE_FAST_TASK,   FUNC_TASK,   8'hFF, 1'b0, 49'd0},
      {MODE_FAST_TASK,   FUNC_COMMIT, 8'h00, 1'b1, {1'b0, 16'd511, 16'd0, 16'd64}},
      {MODE_FAST_TASK,   FUNC_REBOOT, 8'h00, 1'b0, 49'd0},
      {MODE_VALLEY_TASK, FUNC_TASK,   8'hC8, 1'b0, 49'd0},
      {MODE_VALLEY_TASK, FUNC_REBOOT, 8'h00, 1'b0, 49'd0},
      {MODE_VALLEY_TASK, FUNC_COMMIT, 8'h00, 1'b0, 49'd0},
      {MODE_VALLEY_TASK, FUNC_COMMIT, 8'hFF, 1'b0, 49'd0},
      {MODE_WICKED,      FUNC_TASK,   8'h80, 1'b0, 49'd0},
      {MODE_WICKED,      FUNC_REBOOT, 8'h00, 1'b1, {1'b0, 16'd0,   16'd0, 16'd96}},
      {MODE_WICKED,      FUNC_TASK,   8'h01, 1'b0, 49'd0},
      {MODE_WICKED,      FUNC_REBOOT, 8'h00, 1'b1, {1'b0, 16'd0,   16'd0, 16'd1}},
      {MODE_WICKED,      FUNC_TASK,   8'h00, 1'b0, 49'd0},
      {MODE_UNDEF_TOP,   FUNC_COMMIT, 8'h00, 1'b0, 49'd0},
      {MODE_UNDEF_TOP,   FUNC_NOP,    8'hFF, 1'b0, 49'd0},
      {MODE_VALLEY,      FUNC_TASK,   8'h55, 1'b0, 49'd0},
      {MODE_VALLEY,      FUNC_REBOOT, 8'h00, 1'b0, 49'd0}
    };
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    mode_now = MODE_SLOW;
    foreach (plan[i]) begin
      if (plan[i].mode != mode_now) begin
        settle();
        set_mode(plan[i].mode);
        mode_now = plan[i].mode;
      end
      send_item(plan[i].f, plan[i].w, plan[i].typed, plan[i].want);
    end

    // Every mode code once in order, then a wrap burst, then random modes.
    phase = 0;
    goal = items_sent + RANDOM_ITEMS;
    while (items_sent < goal) begin
      settle();
      quiet = ($urandom_range(0, 3) == 0);
      if (phase < 8) mode_now = mode_t'(phase);
      else if (phase == 8) mode_now = MODE_VALLEY_TASK;
      else mode_now = mode_t'($urandom_range(0, 7));
      set_mode(mode_now);
      if (phase == 2) hold_req = 1'b1;
      if (phase == 8) wrap_burst();
      else power_cycles($urandom_range(60, 110), phase == 4);
      phase++;
    end
    settle();
    repeat (4) @(posedge clk);

    if (status_due_q.size() != 0) begin
      mismatches++;
      $display("%0t: %0d results never arrived", $time, status_due_q.size());
    end
    $display("%0d items over %0d mode settings: %0d reboots, %0d commits, %0d results at budget",
             items_sent, n_mode_writes, n_reboots, n_commits, n_reached);
    $display("%0d mismatches", mismatches);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/atcb_pkg.sv
sv/adaptive_task_coalescing_budget_core.sv
tb/testbench.sv
